// ----- src/mbrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared constants and codes for the modbus rtu request parser
// ----------------------------------------------------------------------------
package mbrtu_pkg;

   // field widths
   localparam int unsigned ByteW  = 8;
   localparam int unsigned CountW = 9;
   localparam int unsigned CrcW   = 16;
   localparam int unsigned TickW  = 16;
   localparam int unsigned KindW  = 2;
   localparam int unsigned CsrW   = 16;

   // event kinds on the request channel
   localparam logic EvByte = 1'b0;
   localparam logic EvTick = 1'b1;

   // result kinds on the response channel
   localparam logic [KindW-1:0] ResData   = 2'd0;
   localparam logic [KindW-1:0] ResGood   = 2'd1;
   localparam logic [KindW-1:0] ResCrcErr = 2'd2;

   // register indexes
   localparam logic CsrSlaveAddr = 1'b0;
   localparam logic CsrTimeout   = 1'b1;

   // register reset values
   localparam logic [ByteW-1:0] SlaveAddrReset = 8'd1;
   localparam logic [TickW-1:0] TimeoutReset   = 16'd10;

   // crc-16/modbus
   localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
   localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

   // function codes and data lengths
   localparam logic [ByteW-1:0]  FnFirstShort  = 8'd1;
   localparam logic [ByteW-1:0]  FnLastShort   = 8'd6;
   localparam logic [ByteW-1:0]  FnWriteMulti  = 8'd16;
   localparam logic [CountW-1:0] ShortLen      = 9'd4;
   localparam logic [CountW-1:0] MultiHdrLen   = 9'd5;

   localparam logic [TickW-1:0] TickMax = 16'hFFFF;

endpackage

// ----- src/mbrtu_req_if.sv -----
// ----------------------------------------------------------------------------
// mbrtu_req_if
// request channel: received bytes and millisecond ticks
// ----------------------------------------------------------------------------
interface mbrtu_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [mbrtu_pkg::ByteW-1:0]   rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ----- src/mbrtu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mbrtu_rsp_if
// response channel: data bytes and frame end results
// ----------------------------------------------------------------------------
interface mbrtu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mbrtu_pkg::KindW-1:0]    result_kind;
   logic [mbrtu_pkg::ByteW-1:0]    payload_byte;
   logic [mbrtu_pkg::CountW-1:0]   byte_index;
   logic [mbrtu_pkg::ByteW-1:0]    function_code;
   logic [mbrtu_pkg::CountW-1:0]   frame_length;
   logic                           last;

   modport source (output valid, output result_kind, output payload_byte,
                   output byte_index, output function_code, output frame_length,
                   output last, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input byte_index, input function_code, input frame_length,
                   input last, output ready);
endinterface

// ----- src/mbrtu_crc16_byte.sv -----
// ----------------------------------------------------------------------------
// mbrtu_crc16_byte
// one byte step of crc-16/modbus, reflected, lsb first
// ----------------------------------------------------------------------------
module mbrtu_crc16_byte (
   input  logic [mbrtu_pkg::CrcW-1:0]  crc_in,
   input  logic [mbrtu_pkg::ByteW-1:0] data_in,
   output logic [mbrtu_pkg::CrcW-1:0]  crc_out
);

   always_comb begin
      logic [mbrtu_pkg::CrcW-1:0] c;
      c = crc_in ^ {{(mbrtu_pkg::CrcW-mbrtu_pkg::ByteW){1'b0}}, data_in};
      for (int i = 0; i < mbrtu_pkg::ByteW; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mbrtu_pkg::CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

// ----- src/modbus_rtu_request_parser_core.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_request_parser_core
// modbus rtu slave request parser with crc-16/modbus check
// ----------------------------------------------------------------------------
// The parser takes one event per transfer on req_chan: a received byte
// (kind 0) or a one millisecond tick (kind 1). In idle it waits for a byte
// equal to slave_address, then takes the function code. Codes 1 to 6 carry
// four data bytes, code 16 carries five header bytes plus the count found in
// data byte 4, every other code carries none. Each data byte leaves on
// rsp_chan as it arrives, with its index; after the two crc bytes (low byte
// first) a single frame end transfer reports good or crc error together with
// the data length, and the parser returns to idle. While a frame is open,
// ticks count up and once more than timeout_ticks have passed since the last
// byte the frame is dropped without any result. Events are taken at one per
// clock: an input register holds the event, one pass of logic (the bytewise
// crc update is the longest path) updates the parser state and loads the
// output register. req_chan.ready drops only while the output register is
// full and not being taken and the input register is also occupied. The
// registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while the parser is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module modbus_rtu_request_parser_core (
   input  logic                         clock,
   input  logic                         reset,
   mbrtu_req_if.sink                    req_chan,
   mbrtu_rsp_if.source                  rsp_chan,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [mbrtu_pkg::CsrW-1:0]   csr_wdata
);

   // parser phases
   localparam logic [2:0] PhIdle = 3'd0;
   localparam logic [2:0] PhFunc = 3'd1;
   localparam logic [2:0] PhData = 3'd2;
   localparam logic [2:0] PhCrcL = 3'd3;
   localparam logic [2:0] PhCrcH = 3'd4;

   // configuration registers
   logic [mbrtu_pkg::ByteW-1:0]  slave_addr_ff;
   logic [mbrtu_pkg::TickW-1:0]  timeout_ff;

   // input register
   logic                         in_valid_ff;
   logic                         in_kind_ff;
   logic [mbrtu_pkg::ByteW-1:0]  in_byte_ff;

   // parser state
   logic [2:0]                   phase_ff, phase_in;
   logic [mbrtu_pkg::ByteW-1:0]  func_ff, func_in;
   logic [mbrtu_pkg::CrcW-1:0]   crc_ff, crc_in;
   logic [mbrtu_pkg::ByteW-1:0]  crc_low_ff, crc_low_in;
   logic [mbrtu_pkg::CountW-1:0] count_ff, count_in;
   logic [mbrtu_pkg::CountW-1:0] expect_ff, expect_in;
   logic [mbrtu_pkg::TickW-1:0]  ticks_ff, ticks_in;

   // output register
   logic                         out_valid_ff, out_valid_in;
   logic [mbrtu_pkg::KindW-1:0]  out_kind_ff, out_kind_in;
   logic [mbrtu_pkg::ByteW-1:0]  out_byte_ff, out_byte_in;
   logic [mbrtu_pkg::CountW-1:0] out_index_ff, out_index_in;
   logic [mbrtu_pkg::ByteW-1:0]  out_func_ff, out_func_in;
   logic [mbrtu_pkg::CountW-1:0] out_len_ff, out_len_in;
   logic                         out_last_ff, out_last_in;

   // handshake control
   logic out_free;
   logic advance;
   logic req_take;
   logic res_valid;

   // crc datapath
   logic [mbrtu_pkg::CrcW-1:0]   crc_seed;
   logic [mbrtu_pkg::CrcW-1:0]   crc_next;
   logic [mbrtu_pkg::CountW-1:0] count_plus;
   logic [mbrtu_pkg::TickW-1:0]  ticks_inc;
   logic [mbrtu_pkg::CrcW-1:0]   crc_rx;

   // output register frees when empty or being taken this cycle
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // the address byte starts a fresh crc
   assign crc_seed = (phase_ff == PhIdle) ? mbrtu_pkg::CrcInit : crc_ff;

   mbrtu_crc16_byte u_crc (
      .crc_in  (crc_seed),
      .data_in (in_byte_ff),
      .crc_out (crc_next)
   );

   assign count_plus = count_ff + 9'd1;
   assign ticks_inc  = (ticks_ff != mbrtu_pkg::TickMax) ? ticks_ff + 16'd1 : ticks_ff;
   assign crc_rx     = {in_byte_ff, crc_low_ff};

   // one pass of the parser for the event in the input register
   always_comb begin
      phase_in   = phase_ff;
      func_in    = func_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      count_in   = count_ff;
      expect_in  = expect_ff;
      ticks_in   = ticks_ff;

      res_valid    = 1'b0;
      out_kind_in  = mbrtu_pkg::ResData;
      out_byte_in  = in_byte_ff;
      out_index_in = count_ff;
      out_func_in  = func_ff;
      out_len_in   = '0;
      out_last_in  = 1'b0;

      if (in_kind_ff == mbrtu_pkg::EvTick) begin
         // timeout only runs inside a frame
         if (phase_ff != PhIdle) begin
            ticks_in = ticks_inc;
            if (ticks_inc > timeout_ff) begin
               phase_in   = PhIdle;
               func_in    = '0;
               crc_in     = mbrtu_pkg::CrcInit;
               crc_low_in = '0;
               count_in   = '0;
               expect_in  = '0;
               ticks_in   = '0;
            end
         end
      end else begin
         ticks_in = '0;
         case (phase_ff)
            PhIdle: begin
               if (in_byte_ff == slave_addr_ff) begin
                  crc_in   = crc_next;
                  phase_in = PhFunc;
               end
            end
            PhFunc: begin
               func_in  = in_byte_ff;
               crc_in   = crc_next;
               count_in = '0;
               if (in_byte_ff >= mbrtu_pkg::FnFirstShort &&
                   in_byte_ff <= mbrtu_pkg::FnLastShort) begin
                  expect_in = mbrtu_pkg::ShortLen;
                  phase_in  = PhData;
               end else if (in_byte_ff == mbrtu_pkg::FnWriteMulti) begin
                  expect_in = mbrtu_pkg::MultiHdrLen;
                  phase_in  = PhData;
               end else begin
                  // no data field, straight to the crc
                  expect_in = '0;
                  phase_in  = PhCrcL;
               end
            end
            PhData: begin
               res_valid = 1'b1;
               count_in  = count_plus;
               crc_in    = crc_next;
               // byte count of write-multiple sets the total length
               if (func_ff == mbrtu_pkg::FnWriteMulti &&
                   count_plus == mbrtu_pkg::MultiHdrLen) begin
                  expect_in = {1'b0, in_byte_ff} + mbrtu_pkg::MultiHdrLen;
                  if (count_plus >= {1'b0, in_byte_ff} + mbrtu_pkg::MultiHdrLen) begin
                     phase_in = PhCrcL;
                  end
               end else if (count_plus >= expect_ff) begin
                  phase_in = PhCrcL;
               end
            end
            PhCrcL: begin
               crc_low_in = in_byte_ff;
               phase_in   = PhCrcH;
            end
            PhCrcH: begin
               res_valid    = 1'b1;
               out_kind_in  = (crc_rx == crc_ff) ? mbrtu_pkg::ResGood
                                                 : mbrtu_pkg::ResCrcErr;
               out_byte_in  = '0;
               out_index_in = '0;
               out_len_in   = count_ff;
               out_last_in  = 1'b1;
               phase_in     = PhIdle;
               func_in      = '0;
               crc_in       = mbrtu_pkg::CrcInit;
               crc_low_in   = '0;
               count_in     = '0;
               expect_in    = '0;
            end
            default: begin
               phase_in   = PhIdle;
               func_in    = '0;
               crc_in     = mbrtu_pkg::CrcInit;
               crc_low_in = '0;
               count_in   = '0;
               expect_in  = '0;
            end
         endcase
      end
   end

   // output register keeps a stalled result, loads a new one on advance
   always_comb begin
      if (advance) begin
         out_valid_in = res_valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_chan.ready;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= mbrtu_pkg::SlaveAddrReset;
         timeout_ff    <= mbrtu_pkg::TimeoutReset;
      end else if (csr_we) begin
         case (csr_index)
            mbrtu_pkg::CsrSlaveAddr: slave_addr_ff <= csr_wdata[mbrtu_pkg::ByteW-1:0];
            mbrtu_pkg::CsrTimeout:   timeout_ff    <= csr_wdata[mbrtu_pkg::TickW-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_chan.kind;
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhIdle;
         func_ff    <= '0;
         crc_ff     <= mbrtu_pkg::CrcInit;
         crc_low_ff <= '0;
         count_ff   <= '0;
         expect_ff  <= '0;
         ticks_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         func_ff    <= func_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         count_ff   <= count_in;
         expect_ff  <= expect_in;
         ticks_ff   <= ticks_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_kind_ff  <= out_kind_in;
         out_byte_ff  <= out_byte_in;
         out_index_ff <= out_index_in;
         out_func_ff  <= out_func_in;
         out_len_ff   <= out_len_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_kind_ff;
   assign rsp_chan.payload_byte  = out_byte_ff;
   assign rsp_chan.byte_index    = out_index_ff;
   assign rsp_chan.function_code = out_func_ff;
   assign rsp_chan.frame_length  = out_len_ff;
   assign rsp_chan.last          = out_last_ff;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// randomized check of the modbus rtu request parser against a local predictor
// ----------------------------------------------------------------------------
// Received bytes and millisecond ticks go in through the request channel. A
// local parser model works out the data bytes and frame end results that
// each accepted event should cause. The monitor compares every response
// transfer with the oldest outstanding result. A short directed section
// runs first. Several register settings follow, each with mostly well-formed
// frames (random codes, lengths, crc errors, ticks, cut frames) mixed with
// noise. One setting runs with no idle cycles on either side. Another holds
// off the response side for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

   localparam int StallLimit = 2000;   // cycles with no transfer before giving up
   localparam int LongHold   = 300;    // long response hold-off
   localparam int PhaseItems = 45;     // minimum random events per register setting

   // predictor phases
   localparam logic [2:0] PhIdle    = 3'd0;
   localparam logic [2:0] PhFunc    = 3'd1;
   localparam logic [2:0] PhData    = 3'd2;
   localparam logic [2:0] PhCrcLow  = 3'd3;
   localparam logic [2:0] PhCrcHigh = 3'd4;

   typedef struct packed {
      logic                        kind;
      logic [mbrtu_pkg::ByteW-1:0] data;
   } rx_event_type;

   typedef struct packed {
      logic [mbrtu_pkg::KindW-1:0]  rkind;
      logic [mbrtu_pkg::ByteW-1:0]  payload;
      logic [mbrtu_pkg::CountW-1:0] index;
      logic [mbrtu_pkg::ByteW-1:0]  fn;
      logic [mbrtu_pkg::CountW-1:0] length;
      logic                         last;
   } parser_result_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_we;
   logic                        csr_index;
   logic [mbrtu_pkg::CsrW-1:0]  csr_wdata;

   mbrtu_req_if req_chan();
   mbrtu_rsp_if rsp_chan();

   modbus_rtu_request_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rx_event_type                rx_events[$];    // events waiting to be offered
   parser_result_type           results_due[$];  // predicted responses, oldest first
   logic [mbrtu_pkg::ByteW-1:0] frame_bytes[$];  // frame under construction

   // register shadow copies
   logic [mbrtu_pkg::ByteW-1:0] cfg_addr;
   logic [mbrtu_pkg::TickW-1:0] cfg_timeout;

   // predictor state
   logic [2:0]                   ps_phase;
   logic [mbrtu_pkg::ByteW-1:0]  ps_fn;
   logic [mbrtu_pkg::CrcW-1:0]   ps_crc;
   logic [mbrtu_pkg::ByteW-1:0]  ps_crc_lo;
   logic [mbrtu_pkg::CountW-1:0] ps_count;
   logic [mbrtu_pkg::CountW-1:0] ps_total;
   logic [mbrtu_pkg::TickW-1:0]  ps_ticks;

   int mismatches;
   int results_seen;
   int items_queued;
   bit quiet;            // no idle cycles on either side while set
   int hold_requests;    // bumped by the stimulus to ask for a long hold-off
   int hold_served;
   int hold_left;
   int idle_cycles;

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // crc-16/modbus, one byte, lsb first
   // ------------------------------------------------------------------------
   function automatic logic [mbrtu_pkg::CrcW-1:0] crc16_step(
         input logic [mbrtu_pkg::CrcW-1:0] crc,
         input logic [mbrtu_pkg::ByteW-1:0] b);
      logic [mbrtu_pkg::CrcW-1:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void clear_parser();
      ps_phase  = PhIdle;
      ps_fn     = '0;
      ps_crc    = mbrtu_pkg::CrcInit;
      ps_crc_lo = '0;
      ps_count  = '0;
      ps_total  = '0;
      ps_ticks  = '0;
   endfunction

   // ------------------------------------------------------------------------
   // parser model: one accepted event in, zero or one response predicted
   // ------------------------------------------------------------------------
   function automatic void parse_event(input logic kind,
                                       input logic [mbrtu_pkg::ByteW-1:0] b);
      parser_result_type r;
      logic [mbrtu_pkg::CrcW-1:0] rx_crc;
      r = '0;
      if (kind == mbrtu_pkg::EvTick) begin
         // ticks only count inside a frame; past the timeout the frame is dropped
         if (ps_phase != PhIdle) begin
            if (ps_ticks != mbrtu_pkg::TickMax) begin
               ps_ticks = ps_ticks + 16'd1;
            end
            if (ps_ticks > cfg_timeout) begin
               clear_parser();
            end
         end
         return;
      end
      ps_ticks = '0;
      case (ps_phase)
         PhIdle: begin
            // anything but our own address is ignored
            if (b == cfg_addr) begin
               ps_crc   = crc16_step(mbrtu_pkg::CrcInit, b);
               ps_phase = PhFunc;
            end
         end
         PhFunc: begin
            ps_fn  = b;
            ps_crc = crc16_step(ps_crc, b);
            if (b >= mbrtu_pkg::FnFirstShort && b <= mbrtu_pkg::FnLastShort) begin
               ps_total = mbrtu_pkg::ShortLen;
            end else if (b == mbrtu_pkg::FnWriteMulti) begin
               ps_total = mbrtu_pkg::MultiHdrLen;
            end else begin
               ps_total = '0;
            end
            ps_count = '0;
            ps_phase = (ps_total == '0) ? PhCrcLow : PhData;
         end
         PhData: begin
            r.rkind   = mbrtu_pkg::ResData;
            r.payload = b;
            r.index   = ps_count;
            r.fn      = ps_fn;
            results_due.push_back(r);
            ps_count = ps_count + 9'd1;
            ps_crc   = crc16_step(ps_crc, b);
            // write-multiple: the fifth data byte holds the remaining byte count
            if (ps_fn == mbrtu_pkg::FnWriteMulti && ps_count == mbrtu_pkg::MultiHdrLen) begin
               ps_total = {1'b0, b} + mbrtu_pkg::MultiHdrLen;
            end
            if (ps_count >= ps_total) begin
               ps_phase = PhCrcLow;
            end
         end
         PhCrcLow: begin
            ps_crc_lo = b;
            ps_phase  = PhCrcHigh;
         end
         PhCrcHigh: begin
            rx_crc   = {b, ps_crc_lo};
            r.rkind  = (rx_crc == ps_crc) ? mbrtu_pkg::ResGood : mbrtu_pkg::ResCrcErr;
            r.fn     = ps_fn;
            r.length = ps_count;
            r.last   = 1'b1;
            results_due.push_back(r);
            clear_parser();
         end
         default: clear_parser();
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // mismatch reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s got %0h want %0h",
                                   results_seen, name, got, want));
      end
   endtask

   // ------------------------------------------------------------------------
   // request driver: offers the head of rx_events, holds it until the transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      rx_event_type ev;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.kind    <= mbrtu_pkg::EvByte;
         req_chan.rx_byte <= '0;
      end else begin
         // a transfer happened on this edge: the model sees the event now
         if (req_chan.valid && req_chan.ready) begin
            ev = rx_events.pop_front();
            parse_event(ev.kind, ev.data);
         end
         // an offered event stays put until it is taken
         if (!req_chan.valid || req_chan.ready) begin
            if (rx_events.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
               req_chan.valid   <= 1'b1;
               req_chan.kind    <= rx_events[0].kind;
               req_chan.rx_byte <= rx_events[0].data;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor: random back-pressure, long hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      parser_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected response kind %0d byte %0h",
                                         rsp_chan.result_kind, rsp_chan.payload_byte));
            end else begin
               want = results_due.pop_front();
               check_field("result_kind", 16'(rsp_chan.result_kind), 16'(want.rkind));
               check_field("payload_byte", 16'(rsp_chan.payload_byte), 16'(want.payload));
               check_field("byte_index", 16'(rsp_chan.byte_index), 16'(want.index));
               check_field("function_code", 16'(rsp_chan.function_code), 16'(want.fn));
               check_field("frame_length", 16'(rsp_chan.frame_length), 16'(want.length));
               check_field("last", 16'(rsp_chan.last), 16'(want.last));
            end
            results_seen++;
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(99) >= 35);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any transfer on either channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_event(input logic kind, input logic [mbrtu_pkg::ByteW-1:0] data);
      rx_event_type ev;
      ev.kind = kind;
      ev.data = data;
      rx_events.push_back(ev);
      items_queued++;
   endtask

   task automatic start_frame(input logic [mbrtu_pkg::ByteW-1:0] addr,
                              input logic [mbrtu_pkg::ByteW-1:0] fn);
      frame_bytes.delete();
      frame_bytes.push_back(addr);
      frame_bytes.push_back(fn);
   endtask

   // append the crc and queue the frame; cut > 0 keeps only the first cut bytes
   // tick_mode: 0 none, 1 one tick between bytes, 2 random ticks between bytes
   task automatic send_frame(input bit corrupt, input int cut, input int tick_mode);
      logic [mbrtu_pkg::CrcW-1:0] crc;
      int n;
      crc = mbrtu_pkg::CrcInit;
      foreach (frame_bytes[i]) begin
         crc = crc16_step(crc, frame_bytes[i]);
      end
      if (corrupt) begin
         crc = crc ^ (16'h0001 << $urandom_range(15));
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (i > 0 && tick_mode == 1) begin
            push_event(mbrtu_pkg::EvTick, 8'($urandom_range(255)));
         end else if (i > 0 && tick_mode == 2 && $urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) begin
               push_event(mbrtu_pkg::EvTick, 8'($urandom_range(255)));
            end
         end
         push_event(mbrtu_pkg::EvByte, frame_bytes[i]);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [mbrtu_pkg::CsrW-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == mbrtu_pkg::CsrSlaveAddr) begin
         cfg_addr = val[mbrtu_pkg::ByteW-1:0];
      end else begin
         cfg_timeout = val[mbrtu_pkg::TickW-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every event to be taken and every response to come back
   task automatic drain();
      while (rx_events.size() != 0 || results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // drain, then finish any open frame with filler bytes so the parser is idle
   task automatic settle();
      drain();
      while (ps_phase != PhIdle) begin
         push_event(mbrtu_pkg::EvByte, 8'($urandom_range(255)));
         drain();
      end
   endtask

   // one random frame for the current slave address
   task automatic random_frame();
      logic [mbrtu_pkg::ByteW-1:0] fn;
      logic [mbrtu_pkg::ByteW-1:0] count;
      int roll;
      int cut;
      roll = $urandom_range(99);
      if (roll < 40) begin
         fn = 8'($urandom_range(mbrtu_pkg::FnFirstShort, mbrtu_pkg::FnLastShort));
      end else if (roll < 65) begin
         fn = mbrtu_pkg::FnWriteMulti;
      end else begin
         fn = 8'($urandom_range(255));
      end
      start_frame(cfg_addr, fn);
      if (fn >= mbrtu_pkg::FnFirstShort && fn <= mbrtu_pkg::FnLastShort) begin
         repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
      end else if (fn == mbrtu_pkg::FnWriteMulti) begin
         // short write-multiple payloads, now and then a long one
         count = ($urandom_range(99) < 3) ? 8'($urandom_range(9, 255))
                                          : 8'($urandom_range(0, 8));
         repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
         frame_bytes.push_back(count);
         repeat (count) frame_bytes.push_back(8'($urandom_range(255)));
      end
      cut = 0;
      if ($urandom_range(99) < 10) begin
         cut = $urandom_range(1, frame_bytes.size() + 1);
      end
      send_frame($urandom_range(99) < 15, cut, 2);
      // a cut frame is left to time out when the timeout is short enough
      if (cut > 0 && cfg_timeout < 64) begin
         repeat (cfg_timeout + 1) begin
            push_event(mbrtu_pkg::EvTick, 8'($urandom_range(255)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [mbrtu_pkg::ByteW-1:0] addr_list[5];
      logic [mbrtu_pkg::TickW-1:0] tmo_list[5];
      int start;
      int roll;

      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = mbrtu_pkg::CsrSlaveAddr;
      csr_wdata     = '0;
      mismatches    = 0;
      results_seen  = 0;
      items_queued  = 0;
      quiet         = 1'b0;
      hold_requests = 0;
      hold_served   = 0;
      hold_left     = 0;
      idle_cycles   = 0;
      cfg_addr      = mbrtu_pkg::SlaveAddrReset;
      cfg_timeout   = mbrtu_pkg::TimeoutReset;
      clear_parser();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: a tight timeout so a couple of ticks drop a frame
      write_reg(mbrtu_pkg::CsrTimeout, 16'd1);

      // tick in idle and a foreign address are both ignored
      push_event(mbrtu_pkg::EvTick, 8'h00);
      push_event(mbrtu_pkg::EvByte, 8'hFF);

      // read-type frame with extreme data, good crc
      start_frame(cfg_addr, mbrtu_pkg::FnFirstShort + 8'd2);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h80);
      frame_bytes.push_back(8'h7F);
      send_frame(1'b0, 0, 0);

      // write-multiple with a zero count ends after the header, bad crc
      start_frame(cfg_addr, mbrtu_pkg::FnWriteMulti);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      send_frame(1'b1, 0, 0);

      // code without data, a tick between each byte: every byte clears the count
      start_frame(cfg_addr, 8'hFF);
      send_frame(1'b0, 0, 1);

      // two ticks after the function code exceed the timeout: frame dropped
      push_event(mbrtu_pkg::EvByte, cfg_addr);
      push_event(mbrtu_pkg::EvByte, mbrtu_pkg::FnFirstShort + 8'd1);
      push_event(mbrtu_pkg::EvTick, 8'hAA);
      push_event(mbrtu_pkg::EvTick, 8'h55);
      settle();

      // random phases over several register settings
      addr_list = '{8'h00, 8'hFF, 8'h5A, 8'h00, mbrtu_pkg::SlaveAddrReset};
      tmo_list  = '{16'd0, mbrtu_pkg::TickMax, 16'd3, 16'd0, mbrtu_pkg::TimeoutReset};
      addr_list[3] = 8'($urandom_range(255));
      tmo_list[3]  = 16'($urandom_range(4, 40));

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(mbrtu_pkg::CsrSlaveAddr, {8'h00, addr_list[ph]});
         write_reg(mbrtu_pkg::CsrTimeout, tmo_list[ph]);
         quiet = (ph == 1);
         start = items_queued;
         if (ph == 1) begin
            // longest write-multiple frame: 260 data bytes
            start_frame(cfg_addr, mbrtu_pkg::FnWriteMulti);
            repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
            frame_bytes.push_back(8'hFF);
            repeat (255) frame_bytes.push_back(8'($urandom_range(255)));
            send_frame(1'b0, 0, 0);
            start = items_queued;
         end
         while (items_queued - start < PhaseItems) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
               random_frame();
            end else if (roll < 90) begin
               push_event(mbrtu_pkg::EvByte, 8'($urandom_range(255)));
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  push_event(mbrtu_pkg::EvTick, 8'($urandom_range(255)));
               end
            end
         end
         if (ph == 2) begin
            // response side stalls while the driver keeps offering events
            hold_requests++;
         end
         // sender waits here for every outstanding response before moving on
         settle();
      end
      quiet = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
